// File: src/mcc_pkg.sv
`default_nettype none
// ============================================================================
// mcc_pkg
// Shared types and constants for the magnetometer correction and calibration
// block: sequencer states, transaction kinds, status codes, register indexes
// and fixed-point constants.
// ============================================================================
package mcc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_ADJ,
        ST_MUL_UNIT,
        ST_DIV_LOAD,
        ST_DIV,
        ST_MUL_GAIN,
        ST_ROUND,
        ST_FIN,
        ST_DONE
    } t_state;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_NOT_READY = 3'd1;
    localparam logic [2:0] STATUS_OVERFLOW  = 3'd2;
    localparam logic [2:0] STATUS_STARTED   = 3'd3;
    localparam logic [2:0] STATUS_CAL       = 3'd4;
    localparam logic [2:0] STATUS_DEGEN     = 3'd5;

    localparam logic [2:0] REG_SENS   = 3'd0;
    localparam logic [2:0] REG_BIAS_X = 3'd1;
    localparam logic [2:0] REG_BIAS_Y = 3'd2;
    localparam logic [2:0] REG_BIAS_Z = 3'd3;
    localparam logic [2:0] REG_GAIN_X = 3'd4;
    localparam logic [2:0] REG_GAIN_Y = 3'd5;
    localparam logic [2:0] REG_GAIN_Z = 3'd6;

    localparam logic [23:0] SENS_RESET  = 24'h808080;
    localparam logic [8:0]  SENS_OFFSET = 9'd128;
    localparam logic [15:0] UNIT_MUL    = 16'd307;
    localparam logic [31:0] UNIT_HALF   = 32'd1638;
    // floor(x / 3276) = ((x >> 2) * RECIP_819) >> 40, exact for any x below 2^32
    localparam logic [31:0] RECIP_819   = 32'h5005_0051;
    localparam logic [4:0]  FIN_STEPS   = 5'd16;
    localparam logic [15:0] GAIN_ONE    = 16'd4096;
    localparam logic [15:0] GAIN_MAX    = 16'hFFFF;
    localparam logic [39:0] RND_HALF    = 40'd2048;

    localparam logic signed [25:0] VAL_MAX = 26'sh1FFFFFF;
    localparam logic signed [25:0] VAL_MIN = -26'sh2000000;
    localparam logic [27:0] SAT_POS = 28'd33554431;
    localparam logic [27:0] SAT_NEG = 28'd33554432;

endpackage
`default_nettype wire

// File: src/magnetometer_correct_and_calibrate.sv
`default_nettype none
// ============================================================================
// magnetometer_correct_and_calibrate
// Corrects raw three-axis magnetometer readings (unit scale, sensitivity,
// bias, gain) and runs min/max hard/soft-iron calibration.
// ============================================================================
// Sequencing: a good sample runs, per axis, the adjust, unit, reciprocal and
// gain multiplies, then a round step, before its result goes out.
// Rejected samples and start transactions go straight to the output step.
// Finish finds the centres, then each axis gain through the 16-step divider.
// Throughput: one transaction at a time; a full output register holds it.
// Reset: synchronous active low; clears sequencer, trackers and registers.
module magnetometer_correct_and_calibrate (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // APB configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input stream
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // status_one, status_two, raw_x, raw_y, raw_z
    input  wire logic [63:0]  i_s_tdata,
    // kind
    input  wire logic [1:0]   i_s_tuser,
    // output stream
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // value_x, value_y, value_z, gain_x, gain_y, gain_z, 2 zero bits
    output logic [127:0]      o_m_tdata,
    // status
    output logic [2:0]        o_m_tuser
);
    import mcc_pkg::*;

    t_state r_state, n_state;

    logic [23:0]        r_sens;
    logic signed [21:0] r_bias [3];
    logic [15:0]        r_gcfg [3];

    logic               r_tracking, n_tracking;
    logic               r_seen, n_seen;
    logic signed [25:0] r_min [3], n_min [3];
    logic signed [25:0] r_max [3], n_max [3];

    logic signed [15:0] r_raw [3], n_raw [3];
    logic [1:0]         r_axis, n_axis;
    logic               r_fin, n_fin;
    logic               r_neg, n_neg;
    logic [39:0]        r_prod, n_prod;
    logic [40:0]        r_num, n_num;
    logic [27:0]        r_rem, n_rem;
    logic [27:0]        r_den, n_den;
    logic [20:0]        r_quo, n_quo;
    logic [4:0]         r_cnt, n_cnt;
    logic [27:0]        r_sum, n_sum;
    logic [25:0]        r_rng [3], n_rng [3];
    logic [2:0]         r_status, n_status;
    logic signed [25:0] r_val [3], n_val [3];
    logic [15:0]        r_gain [3], n_gain [3];

    logic               r_o_valid, n_o_valid;
    logic [2:0]         r_o_status, n_o_status;
    logic signed [25:0] r_o_val [3], n_o_val [3];
    logic [15:0]        r_o_gain [3], n_o_gain [3];

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    logic [7:0]         sens_byte;
    logic [8:0]         adj;
    logic signed [16:0] raw_ext;
    logic [16:0]        raw_abs;
    logic [31:0]        smp_num;
    logic [25:0]        fin_rng;
    logic [27:0]        fin_den;
    logic [40:0]        fin_num;
    logic               fin_sat;
    logic [28:0]        div_t;
    logic [28:0]        div_diff;
    logic               div_ge;
    logic signed [23:0] sc;
    logic signed [23:0] bias_ext;
    logic signed [23:0] dval;
    logic [23:0]        dabs;
    logic [39:0]        rsum;
    logic [27:0]        rq;
    logic [27:0]        rq_neg;
    logic signed [25:0] rval;
    logic signed [26:0] fin_s [3];
    logic signed [26:0] fin_r [3];
    logic               cfg_wr;
    logic               s_acc;

    assign pready     = 1'b1;
    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign cfg_wr     = psel && penable && pwrite;

    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_status;
    assign o_m_tdata  = {2'b00, r_o_gain[2], r_o_gain[1], r_o_gain[0],
                         r_o_val[2], r_o_val[1], r_o_val[0]};

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        case (r_axis)
            2'd0:    sens_byte = r_sens[7:0];
            2'd1:    sens_byte = r_sens[15:8];
            default: sens_byte = r_sens[23:16];
        endcase
    end

    assign adj     = {1'b0, sens_byte} + SENS_OFFSET;
    assign raw_ext = {r_raw[r_axis][15], r_raw[r_axis]};
    assign raw_abs = r_raw[r_axis][15] ? 17'(-raw_ext) : 17'(raw_ext);
    assign smp_num = r_prod[31:0] + UNIT_HALF;

    assign fin_rng = r_rng[r_axis];
    assign fin_den = {2'b00, fin_rng} + {1'b0, fin_rng, 1'b0};
    assign fin_num = {1'b0, r_sum, 12'b0} + {14'b0, fin_den[27:1]};
    assign fin_sat = ({3'b000, fin_num[40:16]} >= fin_den);

    assign div_t    = {r_rem, r_num[40]};
    assign div_diff = div_t - {1'b0, r_den};
    assign div_ge   = (div_t >= {1'b0, r_den});

    assign sc       = r_neg ? -$signed({3'b000, r_quo}) : $signed({3'b000, r_quo});
    assign bias_ext = {{2{r_bias[r_axis][21]}}, r_bias[r_axis]};
    assign dval     = sc - bias_ext;
    assign dabs     = dval[23] ? 24'(-dval) : 24'(dval);

    assign rsum   = r_prod + RND_HALF;
    assign rq     = rsum[39:12];
    assign rq_neg = -rq;

    always_comb begin
        if (r_neg) begin
            rval = (rq > SAT_NEG) ? VAL_MIN : $signed(rq_neg[25:0]);
        end else begin
            rval = (rq > SAT_POS) ? VAL_MAX : $signed(rq[25:0]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fin_s[i] = 27'(r_max[i]) + 27'(r_min[i]);
            fin_r[i] = 27'(r_max[i]) - 27'(r_min[i]);
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_tracking = r_tracking;
        n_seen     = r_seen;
        n_min      = r_min;
        n_max      = r_max;
        n_raw      = r_raw;
        n_axis     = r_axis;
        n_fin      = r_fin;
        n_neg      = r_neg;
        n_prod     = r_prod;
        n_num      = r_num;
        n_rem      = r_rem;
        n_den      = r_den;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_rng      = r_rng;
        n_status   = r_status;
        n_val      = r_val;
        n_gain     = r_gain;
        n_o_valid  = r_o_valid && !i_m_tready;
        n_o_status = r_o_status;
        n_o_val    = r_o_val;
        n_o_gain   = r_o_gain;
        mul_a      = '0;
        mul_b      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    for (int i = 0; i < 3; i++) begin
                        n_val[i]  = '0;
                        n_gain[i] = GAIN_ONE;
                    end
                    n_axis = 2'd0;
                    n_fin  = 1'b0;
                    case (i_s_tuser)
                        KIND_SAMPLE: begin
                            n_raw[0] = $signed(i_s_tdata[31:16]);
                            n_raw[1] = $signed(i_s_tdata[47:32]);
                            n_raw[2] = $signed(i_s_tdata[63:48]);
                            if (!i_s_tdata[0]) begin
                                n_status = STATUS_NOT_READY;
                                n_state  = ST_DONE;
                            end else if (i_s_tdata[11]) begin
                                n_status = STATUS_OVERFLOW;
                                n_state  = ST_DONE;
                            end else begin
                                n_status = STATUS_OK;
                                n_state  = ST_MUL_ADJ;
                            end
                        end
                        KIND_START: begin
                            n_tracking = 1'b1;
                            n_seen     = 1'b0;
                            for (int i = 0; i < 3; i++) begin
                                n_min[i] = VAL_MAX;
                                n_max[i] = VAL_MIN;
                            end
                            n_status = STATUS_STARTED;
                            n_state  = ST_DONE;
                        end
                        KIND_FINISH: begin
                            n_tracking = 1'b0;
                            if (r_tracking && r_seen) begin
                                n_state = ST_FIN;
                            end else begin
                                n_status = STATUS_DEGEN;
                                n_state  = ST_DONE;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL_ADJ: begin
                mul_a   = {15'b0, raw_abs};
                mul_b   = {23'b0, adj};
                n_prod  = mul_p[39:0];
                n_neg   = r_raw[r_axis][15];
                n_state = ST_MUL_UNIT;
            end
            ST_MUL_UNIT: begin
                mul_a   = {8'b0, r_prod[23:0]};
                mul_b   = {16'b0, UNIT_MUL};
                n_prod  = mul_p[39:0];
                n_state = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                n_quo = '0;
                if (!r_fin) begin
                    mul_a   = {2'b00, smp_num[31:2]};
                    mul_b   = RECIP_819;
                    n_quo   = mul_p[60:40];
                    n_state = ST_MUL_GAIN;
                end else if (fin_sat) begin
                    n_gain[r_axis] = GAIN_MAX;
                    if (r_axis == 2'd2) begin
                        n_state = ST_DONE;
                    end else begin
                        n_axis = r_axis + 2'd1;
                    end
                end else begin
                    n_rem   = {3'b000, fin_num[40:16]};
                    n_num   = {fin_num[15:0], 25'b0};
                    n_den   = fin_den;
                    n_cnt   = FIN_STEPS;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem = div_ge ? div_diff[27:0] : div_t[27:0];
                n_num = {r_num[39:0], 1'b0};
                n_quo = {r_quo[19:0], div_ge};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    if (r_fin) begin
                        n_gain[r_axis] = n_quo[15:0];
                        if (r_axis == 2'd2) begin
                            n_state = ST_DONE;
                        end else begin
                            n_axis  = r_axis + 2'd1;
                            n_state = ST_DIV_LOAD;
                        end
                    end else begin
                        n_state = ST_MUL_GAIN;
                    end
                end
            end
            ST_MUL_GAIN: begin
                mul_a   = {8'b0, dabs};
                mul_b   = {16'b0, r_gcfg[r_axis]};
                n_prod  = mul_p[39:0];
                n_neg   = dval[23];
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_val[r_axis] = rval;
                if (r_tracking) begin
                    if (rval < r_min[r_axis]) begin
                        n_min[r_axis] = rval;
                    end
                    if (rval > r_max[r_axis]) begin
                        n_max[r_axis] = rval;
                    end
                end
                if (r_axis == 2'd2) begin
                    n_seen  = r_seen || r_tracking;
                    n_state = ST_DONE;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_MUL_ADJ;
                end
            end
            ST_FIN: begin
                n_sum = 28'(fin_r[0][25:0]) + 28'(fin_r[1][25:0]) + 28'(fin_r[2][25:0]);
                for (int i = 0; i < 3; i++) begin
                    n_rng[i] = fin_r[i][25:0];
                    n_val[i] = fin_s[i][26:1];
                end
                if (fin_r[0] == '0 || fin_r[1] == '0 || fin_r[2] == '0) begin
                    for (int i = 0; i < 3; i++) begin
                        n_val[i] = '0;
                    end
                    n_status = STATUS_DEGEN;
                    n_state  = ST_DONE;
                end else begin
                    n_status = STATUS_CAL;
                    n_fin    = 1'b1;
                    n_axis   = 2'd0;
                    n_state  = ST_DIV_LOAD;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || i_m_tready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_val    = r_val;
                    n_o_gain   = r_gain;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_tracking <= 1'b0;
            r_seen     <= 1'b0;
            r_o_valid  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_min[i] <= VAL_MAX;
                r_max[i] <= VAL_MIN;
            end
        end else begin
            r_state    <= n_state;
            r_tracking <= n_tracking;
            r_seen     <= n_seen;
            r_o_valid  <= n_o_valid;
            r_min      <= n_min;
            r_max      <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw      <= n_raw;
        r_axis     <= n_axis;
        r_fin      <= n_fin;
        r_neg      <= n_neg;
        r_prod     <= n_prod;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_den      <= n_den;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_sum      <= n_sum;
        r_rng      <= n_rng;
        r_status   <= n_status;
        r_val      <= n_val;
        r_gain     <= n_gain;
        r_o_status <= n_o_status;
        r_o_val    <= n_o_val;
        r_o_gain   <= n_o_gain;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= SENS_RESET;
            for (int i = 0; i < 3; i++) begin
                r_bias[i] <= '0;
                r_gcfg[i] <= GAIN_ONE;
            end
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_SENS:   r_sens    <= pwdata[23:0];
                REG_BIAS_X: r_bias[0] <= $signed(pwdata[21:0]);
                REG_BIAS_Y: r_bias[1] <= $signed(pwdata[21:0]);
                REG_BIAS_Z: r_bias[2] <= $signed(pwdata[21:0]);
                REG_GAIN_X: r_gcfg[0] <= pwdata[15:0];
                REG_GAIN_Y: r_gcfg[1] <= pwdata[15:0];
                REG_GAIN_Z: r_gcfg[2] <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SENS:   prdata = {8'b0, r_sens};
            REG_BIAS_X: prdata = {10'b0, r_bias[0]};
            REG_BIAS_Y: prdata = {10'b0, r_bias[1]};
            REG_BIAS_Z: prdata = {10'b0, r_bias[2]};
            REG_GAIN_X: prdata = {16'b0, r_gcfg[0]};
            REG_GAIN_Y: prdata = {16'b0, r_gcfg[1]};
            REG_GAIN_Z: prdata = {16'b0, r_gcfg[2]};
            default:    prdata = '0;
        endcase
    end

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_cnt != 5'd0))
        else $error("divider running with zero step count");

    a_bounds_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> ((r_min[0] <= r_max[0]) && (r_min[1] <= r_max[1])
                    && (r_min[2] <= r_max[2])))
        else $error("tracked minimum above maximum");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (i_s_tuser == KIND_START)) |=> (r_tracking && !r_seen))
        else $error("start transaction did not restart tracking");

    a_seen_needs_tracking: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_seen)) |-> r_tracking)
        else $error("sample marked seen while not tracking");

endmodule
`default_nettype wire

// File: bench/mcc_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// mcc_result_checker
// Watches the configuration port and both streams of the magnetometer block.
// Tracks the register contents, computes the result of every accepted sample,
// start or finish transaction (unit scaling, sensitivity, bias, gain,
// min/max calibration) and compares each output transaction, field by field,
// with the oldest outstanding prediction. Hands the mismatch count and the
// number of outstanding results to the testbench top.
// ============================================================================
module mcc_result_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_psel,
    input  wire logic         i_penable,
    input  wire logic         i_pwrite,
    input  wire logic         i_pready,
    input  wire logic [4:0]   i_paddr,
    input  wire logic [31:0]  i_pwdata,
    input  wire logic         i_s_tvalid,
    input  wire logic         i_s_tready,
    // status_one, status_two, raw_x, raw_y, raw_z
    input  wire logic [63:0]  i_s_tdata,
    // kind
    input  wire logic [1:0]   i_s_tuser,
    input  wire logic         i_m_tvalid,
    input  wire logic         i_m_tready,
    // value_x, value_y, value_z, gain_x, gain_y, gain_z, 2 zero bits
    input  wire logic [127:0] i_m_tdata,
    // status
    input  wire logic [2:0]   i_m_tuser,
    output int                o_fail_count,
    output int                o_pending
);
    import mcc_pkg::*;

    localparam longint SCALE_NUM   = 49120;
    localparam longint SCALE_DEN   = 524160;
    localparam longint GAIN_UNITY  = 4096;
    localparam longint GAIN_CEIL   = 65535;
    localparam longint AXIS_TOP    = 33554431;
    localparam longint AXIS_BOTTOM = -33554432;

    typedef struct packed {
        logic [2:0]       status;
        logic [2:0][25:0] value;
        logic [2:0][15:0] gain;
    } t_reading;

    logic [23:0] sens_bytes;
    longint      bias_q4 [3];
    longint      gain_q12 [3];
    bit          tracking;
    bit          seen_sample;
    longint      axis_lo [3];
    longint      axis_hi [3];
    t_reading    awaited_results [$];
    int          mismatches = 0;
    string       axis_tag [3] = '{"x", "y", "z"};

    function automatic longint round_div(input longint num, input longint den);
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint clamp26(input longint v);
        if (v > AXIS_TOP) return AXIS_TOP;
        if (v < AXIS_BOTTOM) return AXIS_BOTTOM;
        return v;
    endfunction

    function automatic void clear_bounds();
        for (int a = 0; a < 3; a++) begin
            axis_lo[a] = AXIS_TOP;
            axis_hi[a] = AXIS_BOTTOM;
        end
        seen_sample = 1'b0;
    endfunction

    function automatic bit predict_result(input logic [1:0] kind, input logic [63:0] data,
                                          output t_reading res);
        longint raw;
        longint adj;
        longint scaled;
        longint corr;
        longint span [3];
        longint mid [3];
        longint total;
        longint g;
        bit     ok;
        res.status = STATUS_OK;
        res.value  = '0;
        res.gain   = {3{GAIN_ONE}};
        total      = 0;
        case (kind)
            KIND_SAMPLE: begin
                if (!data[0]) begin
                    res.status = STATUS_NOT_READY;
                end else if (data[11]) begin
                    res.status = STATUS_OVERFLOW;
                end else begin
                    for (int a = 0; a < 3; a++) begin
                        raw    = longint'($signed(data[16 + 16 * a +: 16]));
                        adj    = longint'(sens_bytes[8 * a +: 8]) + 128;
                        scaled = round_div(raw * adj * SCALE_NUM, SCALE_DEN);
                        corr   = clamp26(round_div((scaled - bias_q4[a]) * gain_q12[a],
                                                   GAIN_UNITY));
                        res.value[a] = corr[25:0];
                        if (tracking) begin
                            if (corr < axis_lo[a]) axis_lo[a] = corr;
                            if (corr > axis_hi[a]) axis_hi[a] = corr;
                        end
                    end
                    if (tracking) seen_sample = 1'b1;
                end
            end
            KIND_START: begin
                tracking = 1'b1;
                clear_bounds();
                res.status = STATUS_STARTED;
            end
            KIND_FINISH: begin
                ok = tracking && seen_sample;
                tracking = 1'b0;
                if (ok) begin
                    for (int a = 0; a < 3; a++) begin
                        mid[a]  = (axis_hi[a] + axis_lo[a]) >>> 1;
                        span[a] = axis_hi[a] - axis_lo[a];
                        if (span[a] <= 0) ok = 1'b0;
                        total += span[a];
                    end
                end
                if (!ok) begin
                    res.status = STATUS_DEGEN;
                end else begin
                    res.status = STATUS_CAL;
                    for (int a = 0; a < 3; a++) begin
                        g = round_div(total * GAIN_UNITY, 3 * span[a]);
                        if (g > GAIN_CEIL) g = GAIN_CEIL;
                        res.value[a] = mid[a][25:0];
                        res.gain[a]  = g[15:0];
                    end
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_reading want;
        t_reading got;
        t_reading fresh;
        bit       produced;
        if (!i_rst_n) begin
            sens_bytes = SENS_RESET;
            for (int a = 0; a < 3; a++) begin
                bias_q4[a]  = 0;
                gain_q12[a] = GAIN_UNITY;
            end
            tracking = 1'b0;
            clear_bounds();
            awaited_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_SENS:   sens_bytes  = i_pwdata[23:0];
                    REG_BIAS_X: bias_q4[0]  = longint'($signed(i_pwdata[21:0]));
                    REG_BIAS_Y: bias_q4[1]  = longint'($signed(i_pwdata[21:0]));
                    REG_BIAS_Z: bias_q4[2]  = longint'($signed(i_pwdata[21:0]));
                    REG_GAIN_X: gain_q12[0] = longint'(i_pwdata[15:0]);
                    REG_GAIN_Y: gain_q12[1] = longint'(i_pwdata[15:0]);
                    REG_GAIN_Z: gain_q12[2] = longint'(i_pwdata[15:0]);
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tuser;
                for (int a = 0; a < 3; a++) begin
                    got.value[a] = i_m_tdata[26 * a +: 26];
                    got.gain[a]  = i_m_tdata[78 + 16 * a +: 16];
                end
                if (awaited_results.size() == 0) begin
                    $error("result transaction with none outstanding, status %0d",
                           got.status);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.status != got.status) begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        mismatches++;
                    end
                    for (int a = 0; a < 3; a++) begin
                        if (want.value[a] != got.value[a]) begin
                            $error("value_%s expected %0d actual %0d", axis_tag[a],
                                   $signed(want.value[a]), $signed(got.value[a]));
                            mismatches++;
                        end
                        if (want.gain[a] != got.gain[a]) begin
                            $error("gain_%s expected %0d actual %0d", axis_tag[a],
                                   want.gain[a], got.gain[a]);
                            mismatches++;
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                produced = predict_result(i_s_tuser, i_s_tdata, fresh);
                if (produced) awaited_results.push_back(fresh);
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: bench/magnetometer_correct_and_calibrate_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// magnetometer_correct_and_calibrate_tb
// Drives the magnetometer correction and calibration block with a directed
// set of corner transactions, then with randomized calibration runs, free
// samples and noise under several register settings, with random gaps on
// the input stream and random back-pressure on the output stream, but not in
// every fourth phase. The checker module predicts and compares every result.
// ============================================================================
module magnetometer_correct_and_calibrate_tb;
    import mcc_pkg::*;

    localparam int CYCLE_LIMIT  = 1500000;
    localparam int SETTLE_TICKS = 100;
    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 100;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [63:0]   i_s_tdata = '0;
    logic [1:0]    i_s_tuser = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [127:0]  o_m_tdata;
    logic [2:0]    o_m_tuser;

    int  fail_count;
    int  outstanding;
    int  cycle_count = 0;
    int  items_sent = 0;
    int  hold_left = 0;
    bit  no_idle = 1'b0;

    magnetometer_correct_and_calibrate uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    mcc_result_checker result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (outstanding)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("magnetometer_correct_and_calibrate verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (no_idle) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 3) != 0);
            hold_left  <= pick_gap();
        end
    end

    function automatic logic [63:0] pack_reading(input logic [7:0] s1, input logic [7:0] s2,
                                                 input logic [15:0] x, input logic [15:0] y,
                                                 input logic [15:0] z);
        return {z, y, x, s2, s1};
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [63:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        if (kind != 2'd3) items_sent++;
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic quiesce();
        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic program_config(input logic [31:0] sens, input logic [31:0] bx,
                                  input logic [31:0] by, input logic [31:0] bz,
                                  input logic [31:0] gx, input logic [31:0] gy,
                                  input logic [31:0] gz);
        quiesce();
        write_reg(REG_SENS, sens);
        write_reg(REG_BIAS_X, bx);
        write_reg(REG_BIAS_Y, by);
        write_reg(REG_BIAS_Z, bz);
        write_reg(REG_GAIN_X, gx);
        write_reg(REG_GAIN_Y, gy);
        write_reg(REG_GAIN_Z, gz);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] rand_bias();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return 32'($urandom_range(0, 40000)) - 32'd20000;
    endfunction

    function automatic logic [31:0] rand_gain();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
        return $urandom_range(2048, 8192);
    endfunction

    task automatic calibration_run();
        int          count;
        int          center [3];
        int          spread [3];
        int          r;
        logic [15:0] raw [3];
        logic [7:0]  s1;
        logic [7:0]  s2;
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
        for (int a = 0; a < 3; a++) begin
            center[a] = int'($urandom_range(0, 65535)) - 32768;
            r = $urandom_range(0, 19);
            if (r == 0) spread[a] = 0;
            else if (r < 6) spread[a] = $urandom_range(1, 4);
            else if (r < 16) spread[a] = $urandom_range(100, 3000);
            else spread[a] = 32767;
        end
        send_item(KIND_START, {$urandom, $urandom});
        for (int i = 0; i < count; i++) begin
            for (int a = 0; a < 3; a++)
                raw[a] = 16'(center[a] + int'($urandom_range(0, 2 * spread[a])) - spread[a]);
            s1 = $urandom_range(0, 255);
            s2 = $urandom_range(0, 255);
            if ($urandom_range(0, 9) != 0) begin
                s1[0] = 1'b1;
                s2[3] = 1'b0;
            end
            send_item(KIND_SAMPLE, pack_reading(s1, s2, raw[0], raw[1], raw[2]));
            if ($urandom_range(0, 39) == 0) send_item(KIND_START, {$urandom, $urandom});
        end
        send_item(KIND_FINISH, {$urandom, $urandom});
    endtask

    initial begin
        int          target;
        int          pick;
        logic [63:0] noise;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(KIND_SAMPLE, pack_reading(8'h00, 8'h08, 16'h7FFF, 16'h8000, 16'hFFFF));
        send_item(KIND_SAMPLE, pack_reading(8'hFF, 8'h08, 16'h8000, 16'h7FFF, 16'h0000));
        send_item(KIND_SAMPLE, pack_reading(8'h01, 8'hF7, 16'h7FFF, 16'h8000, 16'h0000));
        send_item(KIND_SAMPLE, pack_reading(8'hFE, 8'h00, 16'h1234, 16'h5678, 16'h9ABC));
        send_item(KIND_FINISH, 64'd0);
        send_item(KIND_START, 64'd0);
        send_item(KIND_FINISH, '1);
        send_item(KIND_START, '1);
        send_item(KIND_SAMPLE, pack_reading(8'h01, 8'h00, 16'h0100, 16'hFF00, 16'h0010));
        send_item(KIND_FINISH, 64'd0);
        send_item(KIND_START, 64'd0);
        send_item(KIND_SAMPLE, pack_reading(8'h01, 8'h00, 16'h0000, 16'h0000, 16'h0000));
        send_item(KIND_START, 64'd0);
        send_item(KIND_SAMPLE, pack_reading(8'h01, 8'h00, 16'h0001, 16'h8000, 16'h8000));
        send_item(KIND_SAMPLE, pack_reading(8'h01, 8'h08, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_item(KIND_SAMPLE, pack_reading(8'h00, 8'h00, 16'h8000, 16'h8000, 16'h8000));
        send_item(KIND_SAMPLE, pack_reading(8'h01, 8'h00, 16'h0000, 16'h7FFF, 16'h7FFF));
        send_item(KIND_FINISH, 64'd0);
        send_item(2'd3, '1);
        send_item(KIND_START, 64'd0);
        send_item(KIND_SAMPLE, pack_reading(8'h01, 8'h00, 16'd5, 16'd100, -16'sd100));
        send_item(KIND_SAMPLE, pack_reading(8'h01, 8'h00, 16'd5, 16'd200, -16'sd300));
        send_item(KIND_FINISH, 64'd0);
        send_item(KIND_SAMPLE, pack_reading(8'hFF, 8'hF7, 16'hFFFF, 16'hFFFF, 16'hFFFF));

        target = items_sent;
        for (int ph = 0; ph < PHASES; ph++) begin
            no_idle <= (ph % 4 == 3);
            case (ph)
                0: program_config(32'h0, 32'h0020_0000, 32'h0020_0000, 32'h0020_0000,
                                  32'hFFFF, 32'hFFFF, 32'hFFFF);
                1: program_config(32'hFF_FFFF, 32'h001F_FFFF, 32'h001F_FFFF, 32'h001F_FFFF,
                                  32'h0, 32'h0, 32'h0);
                2: program_config($urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom);
                3: program_config(32'h80_8080, 32'h0, 32'h0, 32'h0,
                                  32'h1000, 32'h1000, 32'h1000);
                default: program_config($urandom_range(0, 24'hFF_FFFF), rand_bias(),
                                        rand_bias(), rand_bias(), rand_gain(),
                                        rand_gain(), rand_gain());
            endcase
            target += (ph < 2) ? PHASE_ITEMS / 2 : PHASE_ITEMS;
            while (items_sent < target) begin
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    calibration_run();
                end else if (pick < 8) begin
                    noise = {$urandom, $urandom};
                    noise[0]  = 1'b1;
                    noise[11] = 1'b0;
                    send_item(KIND_SAMPLE, noise);
                end else begin
                    send_item(2'($urandom_range(0, 3)), {$urandom, $urandom});
                end
                if ($urandom_range(0, 59) == 0) drain();
            end
        end

        quiesce();
        if (fail_count == 0) begin
            $display("magnetometer_correct_and_calibrate verification clean");
        end else begin
            $display("magnetometer_correct_and_calibrate verification failed");
        end
        $finish;
    end

endmodule
